// ----- sv/fdl_pkg.sv -----
// shared types, constants and helpers for the feedback fractional delay
`timescale 1ns / 1ps
package fdl_pkg;

  // store depth default and config port shape
  localparam int STORE_DEPTH_DEF = 262144;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 18;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 2'd1;

  // config reset values
  localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [15:0] SMOOTHING_RST   = 16'd131;

  // shared multiply-accumulate widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SAT_W   = ACC_W - 16;

  // delay in samples, q.16, before wrapping
  localparam int DLY_W = 34;

  // misc arithmetic constants
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [19:0] RECIP5   = 20'd419431;  // ceil(2^21 / 5)
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(32768);

  // accumulator operations, applied to the product of the previous cycle
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_RND,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    acc_op_e                     op;
    logic signed [MUL_A_W-1:0]   a;
    logic signed [MUL_B_W-1:0]   b;
  } mac_ctrl_t;

  // input beat
  typedef struct packed {
    logic signed [23:0] audio_in;
    logic [15:0]        delay_time;
    logic [15:0]        feedback_knob;
    logic [15:0]        wet_mix;
    logic               last_in_block;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [23:0] audio_out;
    logic               last_out;
  } out_beat_t;

  // clamp a wide signed value to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [23:0] r;
    if ((v[SAT_W-1:23] == '0) || (v[SAT_W-1:23] == '1)) begin
      r = v[23:0];
    end else if (v[SAT_W-1]) begin
      r = 24'sh800000;
    end else begin
      r = 24'sh7FFFFF;
    end
    return r;
  endfunction

endpackage

// ----- sv/feedback_fractional_delay.sv -----
// top level: sequencer, address logic and state of the feedback delay
// result is registered after the smoothing, delay, gain, wrap reduction, read,
// tap, feedback and mix states (one wrap reduction step at the default depth)
// the block takes one item at a time; the shared multiplier sets the pace
// reset clears control state, smoothing state and config; the delay memory is
// not swept: entries not yet written since reset read as zero via write tracking
`timescale 1ns / 1ps
module feedback_fractional_delay
  import fdl_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int POS_W     = ADDR_W + 16;
  localparam int RED_STEPS = (DLY_W + 1 - POS_W >= 1) ? DLY_W + 1 - POS_W : 1;
  localparam int CMP_W     = POS_W + RED_STEPS;
  localparam int DIFF_W    = ((POS_W > DLY_W) ? POS_W : DLY_W) + 1;
  localparam logic [CMP_W-1:0]  SPAN_C   = CMP_W'(STORE_DEPTH) << 16;
  localparam logic [CMP_W-1:0]  CMP_INIT = SPAN_C << (RED_STEPS - 1);
  localparam logic [DIFF_W-1:0] SPAN_D   = DIFF_W'(STORE_DEPTH) << 16;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SM_A,
    ST_SM_B,
    ST_SM_C,
    ST_SM_D,
    ST_DL_B,
    ST_DL_C,
    ST_GN_C,
    ST_RED,
    ST_POS,
    ST_RD0,
    ST_RD1,
    ST_TP_B,
    ST_TP_C,
    ST_TP_D,
    ST_FB_B,
    ST_FB_C,
    ST_FB_D,
    ST_MX_B,
    ST_MX_C,
    ST_MX_D
  } state_e;

  state_e                    state_q;
  in_beat_t                  in_q;
  logic [17:0]               rate_q;
  logic [15:0]               coeff_q;
  logic [31:0]               smooth_q;
  logic signed [23:0]        last_tap_q;
  logic signed [23:0]        tap_q;
  logic [16:0]               gain_q;
  logic [DLY_W-1:0]          d_q;
  logic [CMP_W-1:0]          cmp_q;
  logic [ADDR_W-1:0]         wp_q;
  logic                      wrapped_q;
  logic [ADDR_W-1:0]         i1_q;
  logic [15:0]               frac_q;
  logic                      v0_q;
  logic                      v1_q;
  logic                      out_valid_q;
  out_beat_t                 out_q;

  logic signed [ACC_W-1:0]   acc;
  mac_ctrl_t                 mac_ctrl;
  logic [16:0]               c_inv;
  logic [16:0]               f_inv;
  logic [16:0]               w_inv;
  logic [18:0]               knob6p2;
  logic [CMP_W-1:0]          d_cmp;
  logic [CMP_W-1:0]          d_sub;
  logic [DIFF_W-1:0]         diff;
  logic [DIFF_W-1:0]         diff_wrap;
  logic [DIFF_W-1:0]         pos_sel;
  logic [ADDR_W-1:0]         i0;
  logic [ADDR_W-1:0]         raddr;
  logic [23:0]               rdata;
  logic signed [23:0]        y_masked;
  logic                      ram_we;
  logic signed [23:0]        store_val;
  logic signed [23:0]        mix_val;

  // small operand helpers
  assign c_inv   = ONE_Q16 - {1'b0, coeff_q};
  assign f_inv   = ONE_Q16 - {1'b0, frac_q};
  assign w_inv   = ONE_Q16 - {1'b0, in_q.wet_mix};
  assign knob6p2 = {1'b0, in_q.feedback_knob, 2'b00}
                 + {2'b00, in_q.feedback_knob, 1'b0} + 19'd2;

  // delay wrap reduction step
  assign d_cmp = CMP_W'(d_q);
  assign d_sub = d_cmp - cmp_q;

  // read position: write position minus delay, wrapped into the span
  assign diff      = DIFF_W'({wp_q, 16'h0000}) - DIFF_W'(d_q);
  assign diff_wrap = diff + SPAN_D;
  assign pos_sel   = diff[DIFF_W-1] ? diff_wrap : diff;

  // older neighbor of the read pair
  assign i0 = (i1_q == '0) ? LAST_ADDR : i1_q - ADDR_W'(1);

  // memory access
  assign raddr     = (state_q == ST_RD0) ? i0 : i1_q;
  assign ram_we    = (state_q == ST_FB_D);
  assign store_val = sat24(acc[ACC_W-1:16]);
  assign mix_val   = sat24(acc[ACC_W-1:16]);
  assign y_masked  = ((state_q == ST_RD1) ? v0_q : v1_q) ? $signed(rdata) : 24'sd0;

  fdl_ram #(
    .WIDTH(24),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(store_val),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // operand and accumulate schedule for the shared unit
  always_comb begin
    mac_ctrl.op = ACC_HOLD;
    mac_ctrl.a  = '0;
    mac_ctrl.b  = '0;
    unique case (state_q)
      ST_SM_A: begin
        mac_ctrl.a = $signed({1'b0, smooth_q});
        mac_ctrl.b = $signed({3'b000, c_inv});
      end
      ST_SM_B: begin
        mac_ctrl.op = ACC_LOAD_RND;
        mac_ctrl.a  = $signed({1'b0, in_q.delay_time, 16'h0000});
        mac_ctrl.b  = $signed({4'h0, coeff_q});
      end
      ST_SM_C: begin
        mac_ctrl.op = ACC_ADD;
      end
      ST_SM_D: begin
        mac_ctrl.a = $signed({1'b0, acc[47:16]});
        mac_ctrl.b = $signed({2'b00, rate_q});
      end
      ST_DL_B: begin
        mac_ctrl.op = ACC_LOAD;
        mac_ctrl.a  = $signed({14'h0000, knob6p2});
        mac_ctrl.b  = $signed(RECIP5);
      end
      ST_DL_C: begin
        mac_ctrl.op = ACC_LOAD;
      end
      ST_RD1: begin
        mac_ctrl.a = MUL_A_W'(y_masked);
        mac_ctrl.b = $signed({3'b000, f_inv});
      end
      ST_TP_B: begin
        mac_ctrl.op = ACC_LOAD_RND;
        mac_ctrl.a  = MUL_A_W'(y_masked);
        mac_ctrl.b  = $signed({4'h0, frac_q});
      end
      ST_TP_C: begin
        mac_ctrl.op = ACC_ADD;
      end
      ST_TP_D: begin
        mac_ctrl.a = MUL_A_W'(last_tap_q);
        mac_ctrl.b = $signed({3'b000, gain_q});
      end
      ST_FB_B: begin
        mac_ctrl.op = ACC_LOAD_RND;
        mac_ctrl.a  = MUL_A_W'(in_q.audio_in);
        mac_ctrl.b  = $signed({3'b000, ONE_Q16});
      end
      ST_FB_C: begin
        mac_ctrl.op = ACC_ADD;
      end
      ST_FB_D: begin
        mac_ctrl.a = MUL_A_W'(in_q.audio_in);
        mac_ctrl.b = $signed({3'b000, w_inv});
      end
      ST_MX_B: begin
        mac_ctrl.op = ACC_LOAD_RND;
        mac_ctrl.a  = MUL_A_W'(tap_q);
        mac_ctrl.b  = $signed({4'h0, in_q.wet_mix});
      end
      ST_MX_C: begin
        mac_ctrl.op = ACC_ADD;
      end
      default: begin
        mac_ctrl.op = ACC_HOLD;
      end
    endcase
  end

  fdl_mac u_mac (
    .clk_i (clk_i),
    .ctrl_i(mac_ctrl),
    .acc_o (acc)
  );

  // sequencer, config registers and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_q        <= '0;
      rate_q      <= SAMPLE_RATE_RST;
      coeff_q     <= SMOOTHING_RST;
      smooth_q    <= '0;
      last_tap_q  <= '0;
      tap_q       <= '0;
      gain_q      <= '0;
      d_q         <= '0;
      cmp_q       <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      i1_q        <= '0;
      frac_q      <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // config writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SAMPLE_RATE: rate_q  <= cfg_wdata_i;
          REG_SMOOTHING:   coeff_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      // output beat taken, unless a new one replaces it below
      if (out_valid_q && !out_stall_i && (state_q != ST_MX_D)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            state_q <= ST_SM_A;
          end
        end
        ST_SM_A: state_q <= ST_SM_B;
        ST_SM_B: state_q <= ST_SM_C;
        ST_SM_C: state_q <= ST_SM_D;
        ST_SM_D: begin
          smooth_q <= acc[47:16];
          state_q  <= ST_DL_B;
        end
        ST_DL_B: state_q <= ST_DL_C;
        ST_DL_C: begin
          d_q     <= acc[49:16];
          state_q <= ST_GN_C;
        end
        ST_GN_C: begin
          gain_q  <= acc[37:21];
          cmp_q   <= CMP_INIT;
          state_q <= ST_RED;
        end
        // one restoring step per cycle until the delay is below the span
        ST_RED: begin
          if (d_cmp >= cmp_q) begin
            d_q <= d_sub[DLY_W-1:0];
          end
          if (cmp_q == SPAN_C) begin
            state_q <= ST_POS;
          end else begin
            cmp_q <= cmp_q >> 1;
          end
        end
        ST_POS: begin
          i1_q    <= pos_sel[POS_W-1:16];
          frac_q  <= pos_sel[15:0];
          state_q <= ST_RD0;
        end
        ST_RD0: begin
          v0_q    <= wrapped_q || (i0 < wp_q);
          state_q <= ST_RD1;
        end
        ST_RD1: begin
          v1_q    <= wrapped_q || (i1_q < wp_q);
          state_q <= ST_TP_B;
        end
        ST_TP_B: state_q <= ST_TP_C;
        ST_TP_C: state_q <= ST_TP_D;
        ST_TP_D: begin
          tap_q   <= acc[39:16];
          state_q <= ST_FB_B;
        end
        ST_FB_B: state_q <= ST_FB_C;
        ST_FB_C: state_q <= ST_FB_D;
        ST_FB_D: begin
          last_tap_q <= tap_q;
          state_q    <= ST_MX_B;
        end
        ST_MX_B: state_q <= ST_MX_C;
        ST_MX_C: state_q <= ST_MX_D;
        // hold until the output register is free
        ST_MX_D: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.audio_out <= mix_val;
            out_q.last_out  <= in_q.last_in_block;
            out_valid_q     <= 1'b1;
            if (wp_q == LAST_ADDR) begin
              wp_q      <= '0;
              wrapped_q <= 1'b1;
            end else begin
              wp_q <= wp_q + ADDR_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/fdl_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fdl_mac.sv -----
// shared multiplier with registered product and accumulator
`timescale 1ns / 1ps
module fdl_mac
  import fdl_pkg::*;
(
  input  logic                    clk_i,
  input  mac_ctrl_t               ctrl_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // accumulator update from last cycle's product
  always_comb begin
    unique case (ctrl_i.op)
      ACC_LOAD:     acc_d = prod_ext;
      ACC_LOAD_RND: acc_d = prod_ext + $signed(RND_HALF);
      ACC_ADD:      acc_d = acc_q + prod_ext;
      default:      acc_d = acc_q;
    endcase
  end

  // product register then accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= ctrl_i.a * ctrl_i.b;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
